/* rtl/w2s_pkg.sv */
package w2s_pkg;

    // fixed point format of every coordinate and matrix element
    localparam int FRAC_BITS = 16;

    // visible iff 100 * w >= 2^FRAC_BITS, i.e. w >= ceil(2^FRAC_BITS / 100)
    localparam int VIS_MIN = (2 ** FRAC_BITS + 99) / 100;

    // divider: quotient bits resolved per pipeline stage
    localparam int DIV_STEP   = 4;
    localparam int NUM_W      = ((32 + FRAC_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int DIV_STAGES = NUM_W / DIV_STEP;

    // |ndc| < 2^31 * 2^FRAC_BITS / VIS_MIN <= 100 * 2^31, fits 39 bits + sign
    localparam int NDC_W  = 40;
    localparam int HALF_W = 12;
    localparam int PROD_W = HALF_W + 1 + NDC_W;
    localparam int ACC_W  = 66;

    // pipeline stage numbers
    localparam int ST_PROD = 0;
    localparam int ST_CLIP = 1;
    localparam int ST_PREP = 2;
    localparam int ST_SIGN = ST_PREP + DIV_STAGES + 1;
    localparam int ST_MUL  = ST_SIGN + 1;
    localparam int ST_OUT  = ST_MUL + 1;
    localparam int NST     = ST_OUT + 1;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_VOFF   = 2'd2;

    localparam logic [12:0] RST_WIDTH  = 13'd1920;
    localparam logic [12:0] RST_HEIGHT = 13'd1080;
    localparam logic [7:0]  RST_VOFF   = 8'd30;

    // one divider stage word: two dividends sharing the divisor clip w
    typedef struct packed {
        logic             vis;
        logic             neg_x;
        logic             neg_y;
        logic [31:0]      d;
        logic [NUM_W-1:0] num_x;
        logic [31:0]      rem_x;
        logic [NUM_W-1:0] num_y;
        logic [31:0]      rem_y;
    } t_div;

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
            return v[31:0];
        end else if (v[ACC_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

/* rtl/world_to_screen_projection_unit.sv */
// World-to-screen projection: a load word (mode 1) writes one element of the 4x4
// view-projection matrix and gives no result; a project word (mode 0) returns one
// result: visible flag and screen x/y in signed Q16.16, saturated, zero when clip w
// is below 0.01. One word is taken every clock that o_ready is high; a project word's
// result passes through 18 register stages (nine parallel multipliers, clip sums,
// divider setup, twelve divider stages of four quotient bits each, sign, viewport
// multiply, final sum). The two 48-bit restoring dividers are fully pipelined, so
// stalls on the output only back up the pipeline; bubbles are squeezed out. Matrix
// loads affect every project word accepted after them. Configuration writes must be
// made only while the block is idle; the block itself does not enforce this.
module world_to_screen_projection_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic [3:0]         i_matrix_index,
    input  logic signed [31:0] i_matrix_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_visible,
    output logic signed [31:0] o_screen_x,
    output logic signed [31:0] o_screen_y
);

    logic [w2s_pkg::NST-1:0] r_vld;
    logic [w2s_pkg::NST-1:0] w_en;
    logic                    w_acc;

    logic signed [31:0] r_mat [16];
    logic [12:0]        r_width;
    logic [12:0]        r_height;
    logic [7:0]         r_voff;

    logic signed [63:0] r_prod [3][3];
    logic signed [31:0] r_mcol [3];
    logic signed [31:0] r_clip [3];

    w2s_pkg::t_div r_div [w2s_pkg::DIV_STAGES+1];

    logic                              r_vis_s, r_vis_m, r_out_vis;
    logic signed [w2s_pkg::NDC_W-1:0]  r_ndc_x, r_ndc_y;
    logic signed [w2s_pkg::PROD_W-1:0] r_mx, r_my;
    logic signed [31:0]                r_out_x, r_out_y;

    logic [w2s_pkg::HALF_W-1:0] w_hw, w_hh;

    assign w_hw = r_width[12:1];
    assign w_hh = r_height[12:1];

    // stall chain: a stage loads when it is empty or the next one moves
    always_comb begin
        w_en[w2s_pkg::NST-1] = !r_vld[w2s_pkg::NST-1] || i_ready;
        for (int k = w2s_pkg::NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign w_acc   = i_valid && w_en[0];

    // valid bits; load words leave a bubble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid && !i_mode;
            end
            for (int k = 1; k < w2s_pkg::NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // matrix and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < 16; e++) begin
                r_mat[e] <= '0;
            end
            r_width  <= w2s_pkg::RST_WIDTH;
            r_height <= w2s_pkg::RST_HEIGHT;
            r_voff   <= w2s_pkg::RST_VOFF;
        end else begin
            if (w_acc && i_mode) begin
                r_mat[i_matrix_index] <= i_matrix_value;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    w2s_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    w2s_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    w2s_pkg::CFG_VOFF:   r_voff   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // rows 0, 1 and 3: products, then clip sums
    for (genvar r = 0; r < 3; r++) begin : g_row
        localparam int ROW = (r == 2) ? 3 : r;
        logic signed [w2s_pkg::ACC_W-1:0] w_sum;

        always_ff @(posedge i_clk) begin
            if (w_en[w2s_pkg::ST_PROD]) begin
                r_prod[r][0] <= r_mat[ROW*4]     * i_point_x;
                r_prod[r][1] <= r_mat[ROW*4 + 1] * i_point_y;
                r_prod[r][2] <= r_mat[ROW*4 + 2] * i_point_z;
                r_mcol[r]    <= r_mat[ROW*4 + 3];
            end
        end

        // arithmetic shift is floor
        always_comb begin
            w_sum = ($signed({{2{r_prod[r][0][63]}}, r_prod[r][0]}) >>> w2s_pkg::FRAC_BITS)
                  + ($signed({{2{r_prod[r][1][63]}}, r_prod[r][1]}) >>> w2s_pkg::FRAC_BITS)
                  + ($signed({{2{r_prod[r][2][63]}}, r_prod[r][2]}) >>> w2s_pkg::FRAC_BITS)
                  + $signed({{34{r_mcol[r][31]}}, r_mcol[r]});
        end

        always_ff @(posedge i_clk) begin
            if (w_en[w2s_pkg::ST_CLIP]) begin
                r_clip[r] <= w2s_pkg::sat32(w_sum);
            end
        end
    end

    // divider setup: magnitudes of clip << FRAC_BITS, divisor clip w
    logic [31:0] w_ax, w_ay;
    assign w_ax = r_clip[0][31] ? 32'(-r_clip[0]) : 32'(r_clip[0]);
    assign w_ay = r_clip[1][31] ? 32'(-r_clip[1]) : 32'(r_clip[1]);

    always_ff @(posedge i_clk) begin
        if (w_en[w2s_pkg::ST_PREP]) begin
            r_div[0].vis   <= r_clip[2] >= w2s_pkg::VIS_MIN;
            r_div[0].neg_x <= r_clip[0][31];
            r_div[0].neg_y <= r_clip[1][31];
            r_div[0].d     <= r_clip[2];
            r_div[0].num_x <= w2s_pkg::NUM_W'({w_ax, {w2s_pkg::FRAC_BITS{1'b0}}});
            r_div[0].num_y <= w2s_pkg::NUM_W'({w_ay, {w2s_pkg::FRAC_BITS{1'b0}}});
            r_div[0].rem_x <= '0;
            r_div[0].rem_y <= '0;
        end
    end

    // restoring divider, DIV_STEP quotient bits per stage
    for (genvar j = 1; j <= w2s_pkg::DIV_STAGES; j++) begin : g_div
        w2s_pkg::t_div w_v;
        logic [31:0]   w_tx, w_ty;

        always_comb begin
            w_v  = r_div[j-1];
            w_tx = '0;
            w_ty = '0;
            for (int s = 0; s < w2s_pkg::DIV_STEP; s++) begin
                w_tx = {w_v.rem_x[30:0], w_v.num_x[w2s_pkg::NUM_W-1]};
                w_ty = {w_v.rem_y[30:0], w_v.num_y[w2s_pkg::NUM_W-1]};
                w_v.num_x = {w_v.num_x[w2s_pkg::NUM_W-2:0], 1'b0};
                w_v.num_y = {w_v.num_y[w2s_pkg::NUM_W-2:0], 1'b0};
                if (w_tx >= w_v.d) begin
                    w_v.rem_x    = w_tx - w_v.d;
                    w_v.num_x[0] = 1'b1;
                end else begin
                    w_v.rem_x = w_tx;
                end
                if (w_ty >= w_v.d) begin
                    w_v.rem_y    = w_ty - w_v.d;
                    w_v.num_y[0] = 1'b1;
                end else begin
                    w_v.rem_y = w_ty;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[w2s_pkg::ST_PREP + j]) begin
                r_div[j] <= w_v;
            end
        end
    end

    // quotient sign: truncation toward zero
    logic signed [w2s_pkg::NDC_W-1:0] w_qx, w_qy;
    assign w_qx = $signed(r_div[w2s_pkg::DIV_STAGES].num_x[w2s_pkg::NDC_W-1:0]);
    assign w_qy = $signed(r_div[w2s_pkg::DIV_STAGES].num_y[w2s_pkg::NDC_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_en[w2s_pkg::ST_SIGN]) begin
            r_vis_s <= r_div[w2s_pkg::DIV_STAGES].vis;
            r_ndc_x <= r_div[w2s_pkg::DIV_STAGES].neg_x ? -w_qx : w_qx;
            r_ndc_y <= r_div[w2s_pkg::DIV_STAGES].neg_y ? -w_qy : w_qy;
        end
    end

    // viewport scale
    always_ff @(posedge i_clk) begin
        if (w_en[w2s_pkg::ST_MUL]) begin
            r_vis_m <= r_vis_s;
            r_mx    <= $signed({1'b0, w_hw}) * r_ndc_x;
            r_my    <= $signed({1'b0, w_hh}) * r_ndc_y;
        end
    end

    // viewport offset and saturation
    logic signed [w2s_pkg::ACC_W-1:0] w_sx, w_sy;
    always_comb begin
        w_sx = $signed({{(w2s_pkg::ACC_W - w2s_pkg::PROD_W){r_mx[w2s_pkg::PROD_W-1]}}, r_mx})
             + $signed(w2s_pkg::ACC_W'(w_hw) << w2s_pkg::FRAC_BITS);
        w_sy = $signed(w2s_pkg::ACC_W'(w_hh) << w2s_pkg::FRAC_BITS)
             - $signed({{(w2s_pkg::ACC_W - w2s_pkg::PROD_W){r_my[w2s_pkg::PROD_W-1]}}, r_my})
             + $signed(w2s_pkg::ACC_W'(r_voff) << w2s_pkg::FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[w2s_pkg::ST_OUT]) begin
            r_out_vis <= r_vis_m;
            r_out_x   <= r_vis_m ? w2s_pkg::sat32(w_sx) : 32'sd0;
            r_out_y   <= r_vis_m ? w2s_pkg::sat32(w_sy) : 32'sd0;
        end
    end

    assign o_valid    = r_vld[w2s_pkg::NST-1];
    assign o_visible  = r_out_vis;
    assign o_screen_x = r_out_x;
    assign o_screen_y = r_out_y;

endmodule

/* rtl/w2s_checker.sv */
module w2s_props (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [1:0]         i_cfg_index,
    input logic [12:0]        i_cfg_data,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_mode,
    input logic [3:0]         i_matrix_index,
    input logic signed [31:0] i_matrix_value,
    input logic signed [31:0] i_point_x,
    input logic signed [31:0] i_point_y,
    input logic signed [31:0] i_point_z,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_visible,
    input logic signed [31:0] o_screen_x,
    input logic signed [31:0] o_screen_y
);

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word present right after reset");

    // an empty output stage means nothing can be backed up
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output stage is empty");

    // points behind the near limit report zero coordinates
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> o_screen_x == 32'sd0 && o_screen_y == 32'sd0)
        else $error("hidden point with nonzero coordinates");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_visible)
            && $stable(o_screen_x) && $stable(o_screen_y))
        else $error("result word changed while stalled");

endmodule

bind world_to_screen_projection_unit w2s_props u_w2s_props (.*);
